// File: design/s2d_pkg.sv
// s2d_pkg: shared constants and types for the signed integer to decimal ASCII block.
// No dependencies. Used by the interfaces, the digit cell and the top level.
package s2d_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int MAX_DIGITS_DEF  = 10;
   localparam int DEST_WIDTH      = 8;
   localparam int CHAR_WIDTH      = 8;
   localparam int DIGIT_WIDTH     = 4;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'd45;

   // Digit cell operation, shared by every cell of the row
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_CONVERT,
      CELL_SHIFT
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_EMIT
   } state_type;

endpackage

// File: design/s2d_req_if.sv
// s2d_req_if: input channel, valid/ready handshake carrying value and destination.
// Depends on s2d_pkg.
interface s2d_req_if #(
   parameter int VALUE_WIDTH = s2d_pkg::VALUE_WIDTH_DEF
);
   logic                             valid;
   logic                             ready;
   logic signed [VALUE_WIDTH-1:0]    value;
   logic [s2d_pkg::DEST_WIDTH-1:0]   destination;

   modport source (output valid, output value, output destination, input ready);
   modport sink   (input valid, input value, input destination, output ready);
endinterface

// File: design/s2d_rsp_if.sv
// s2d_rsp_if: result channel, valid/ready handshake carrying one character per beat.
// Depends on s2d_pkg.
interface s2d_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [s2d_pkg::CHAR_WIDTH-1:0]   character;
   logic                             last;
   logic [s2d_pkg::DEST_WIDTH-1:0]   destination_res;

   modport source (output valid, output character, output last, output destination_res,
                   input ready);
   modport sink   (input valid, input character, input last, input destination_res,
                   output ready);
endinterface

// File: design/s2d_cell.sv
// s2d_cell: one BCD digit of the shift-and-add-3 row; also shifts digits up for output.
// Depends on s2d_pkg.
module s2d_cell (
   input  logic                               clock,
   input  s2d_pkg::cell_op_type               op,
   input  logic                               bit_in,
   input  logic [s2d_pkg::DIGIT_WIDTH-1:0]    digit_in,
   output logic                               bit_out,
   output logic [s2d_pkg::DIGIT_WIDTH-1:0]    digit_out
);
   logic [s2d_pkg::DIGIT_WIDTH-1:0] digit_ff;
   logic [s2d_pkg::DIGIT_WIDTH-1:0] digit_in_next;
   logic [s2d_pkg::DIGIT_WIDTH-1:0] adjusted;

   // add 3 when the digit would reach ten after doubling
   assign adjusted  = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign bit_out   = (op == s2d_pkg::CELL_CONVERT) ? adjusted[3] : 1'b0;
   assign digit_out = digit_ff;

   always_comb begin
      unique case (op)
         s2d_pkg::CELL_HOLD:    digit_in_next = digit_ff;
         s2d_pkg::CELL_CLEAR:   digit_in_next = '0;
         s2d_pkg::CELL_CONVERT: digit_in_next = {adjusted[2:0], bit_in};
         s2d_pkg::CELL_SHIFT:   digit_in_next = digit_in;
         default:               digit_in_next = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end
endmodule

// File: design/signed_int_to_decimal_ascii.sv
// signed_int_to_decimal_ascii: prints a signed integer as decimal ASCII, one character a beat.
// Depends on s2d_pkg, s2d_req_if, s2d_rsp_if and s2d_cell.
//
//   port      dir   beat carries
//   req_chan  in    value (signed, VALUE_WIDTH), destination (8)
//   rsp_chan  out   character (8), last (1), destination_res (8)
//
// One number is accepted while idle, then converted by shift-and-add-3 through the row
// of MAX_DIGITS digit cells, one magnitude bit at a time; a '-' follows when negative, then
// the digits shift out of the top cell (leading zeros are dropped without a beat).
// req_chan.ready is high only while idle; the last character may still wait in the output
// register while the next number is taken. A stalled rsp_chan holds the row only while a
// character waits to go out; conversion and dropped leading zeros go on.
// Reset is synchronous, active high, and clears the control state and the held destination.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_WIDTH = s2d_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = s2d_pkg::MAX_DIGITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   s2d_req_if.sink       req_chan,
   s2d_rsp_if.source     rsp_chan
);
   localparam int BitCntW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
   localparam int RemW    = $clog2(MAX_DIGITS + 1);

   s2d_pkg::state_type                state_ff, state_in;
   logic [VALUE_WIDTH-1:0]            mag_ff, mag_in;
   logic [BitCntW-1:0]                bit_cnt_ff, bit_cnt_in;
   logic [RemW-1:0]                   remain_ff, remain_in;
   logic                              neg_ff, neg_in;
   logic                              ovf_ff, ovf_in;
   logic                              started_ff, started_in;
   logic [s2d_pkg::DEST_WIDTH-1:0]    dest_ff, dest_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [s2d_pkg::CHAR_WIDTH-1:0]    char_ff, char_in;
   logic                              last_ff, last_in;
   logic [s2d_pkg::DEST_WIDTH-1:0]    dest_res_ff, dest_res_in;

   s2d_pkg::cell_op_type              cell_op;
   logic [MAX_DIGITS-1:0]             cell_bit_in, cell_bit_out;
   logic [s2d_pkg::DIGIT_WIDTH-1:0]   cell_digit [MAX_DIGITS];
   logic [s2d_pkg::DIGIT_WIDTH-1:0]   top_digit;
   logic [VALUE_WIDTH-1:0]            raw;
   logic                              out_free;
   logic                              req_take;

   assign raw       = VALUE_WIDTH'(req_chan.value);
   assign top_digit = cell_digit[MAX_DIGITS-1];
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_take  = req_chan.valid && (state_ff == s2d_pkg::ST_IDLE);

   assign req_chan.ready           = (state_ff == s2d_pkg::ST_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.character       = char_ff;
   assign rsp_chan.last            = last_ff;
   assign rsp_chan.destination_res = dest_res_ff;

   // magnitude bits enter at the bottom cell, most significant first
   assign cell_bit_in[0] = mag_ff[VALUE_WIDTH-1];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
         if (gi > 0) begin : g_link
            assign cell_bit_in[gi] = cell_bit_out[gi-1];
         end
         s2d_cell u_cell (
            .clock     (clock),
            .op        (cell_op),
            .bit_in    (cell_bit_in[gi]),
            .digit_in  ((gi == 0) ? {s2d_pkg::DIGIT_WIDTH{1'b0}} : cell_digit[(gi == 0) ? 0 : gi-1]),
            .bit_out   (cell_bit_out[gi]),
            .digit_out (cell_digit[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bit_cnt_in   = bit_cnt_ff;
      remain_in    = remain_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      started_in   = started_ff;
      dest_in      = dest_ff;
      cell_op      = s2d_pkg::CELL_HOLD;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      dest_res_in  = dest_res_ff;

      unique case (state_ff)
         s2d_pkg::ST_IDLE: begin
            if (req_take) begin
               neg_in     = raw[VALUE_WIDTH-1];
               mag_in     = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
               dest_in    = req_chan.destination;
               bit_cnt_in = BitCntW'(VALUE_WIDTH - 1);
               ovf_in     = 1'b0;
               started_in = 1'b0;
               cell_op    = s2d_pkg::CELL_CLEAR;
               state_in   = s2d_pkg::ST_CONVERT;
            end
         end
         s2d_pkg::ST_CONVERT: begin
            cell_op = s2d_pkg::CELL_CONVERT;
            mag_in  = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            // a carry out of the top cell means more digits than the row holds
            if (cell_bit_out[MAX_DIGITS-1]) begin
               ovf_in = 1'b1;
            end
            bit_cnt_in = bit_cnt_ff - BitCntW'(1);
            if (bit_cnt_ff == '0) begin
               remain_in = RemW'(MAX_DIGITS);
               state_in  = neg_ff ? s2d_pkg::ST_SIGN : s2d_pkg::ST_EMIT;
            end
         end
         s2d_pkg::ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = s2d_pkg::ASCII_MINUS;
               last_in      = 1'b0;
               dest_res_in  = dest_ff;
               state_in     = s2d_pkg::ST_EMIT;
            end
         end
         s2d_pkg::ST_EMIT: begin
            if (!started_ff && !ovf_ff && top_digit == '0 && remain_ff != RemW'(1)) begin
               // leading zero: drop it without a beat
               cell_op   = s2d_pkg::CELL_SHIFT;
               remain_in = remain_ff - RemW'(1);
            end else if (out_free) begin
               cell_op      = s2d_pkg::CELL_SHIFT;
               remain_in    = remain_ff - RemW'(1);
               started_in   = 1'b1;
               rsp_valid_in = 1'b1;
               char_in      = s2d_pkg::ASCII_ZERO
                              + {{(s2d_pkg::CHAR_WIDTH - s2d_pkg::DIGIT_WIDTH){1'b0}}, top_digit};
               last_in      = (remain_ff == RemW'(1));
               dest_res_in  = dest_ff;
               if (remain_ff == RemW'(1)) begin
                  state_in = s2d_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = s2d_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= s2d_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff     <= 1'b0;
         ovf_ff     <= 1'b0;
         started_ff <= 1'b0;
         remain_ff  <= '0;
         bit_cnt_ff <= '0;
         dest_ff    <= '0;
      end else begin
         neg_ff     <= neg_in;
         ovf_ff     <= ovf_in;
         started_ff <= started_in;
         remain_ff  <= remain_in;
         bit_cnt_ff <= bit_cnt_in;
         dest_ff    <= dest_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
      dest_res_ff <= dest_res_in;
   end
endmodule

// File: test/signed_int_to_decimal_ascii_test.sv
// Testbench for signed_int_to_decimal_ascii: corner numbers, then random ones, with a
// bursty sender, a stalling receiver and a checker that predicts every character.
// Depends on s2d_pkg, s2d_req_if, s2d_rsp_if and the block itself.
module signed_int_to_decimal_ascii_test;

   localparam int VW          = s2d_pkg::VALUE_WIDTH_DEF;
   localparam int RANDOM_NUMS = 452;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [VW-1:0]            value;
      logic [s2d_pkg::DEST_WIDTH-1:0]  destination;
   } number_item_type;

   typedef struct packed {
      logic [s2d_pkg::CHAR_WIDTH-1:0]  character;
      logic                            last;
      logic [s2d_pkg::DEST_WIDTH-1:0]  destination;
   } text_beat_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_RANDOM,
      RX_MASK
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   s2d_req_if #(.VALUE_WIDTH(VW)) req_chan ();
   s2d_rsp_if                     rsp_chan ();

   signed_int_to_decimal_ascii #(
      .VALUE_WIDTH (VW),
      .MAX_DIGITS  (s2d_pkg::MAX_DIGITS_DEF)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   number_item_type  numbers_to_send [$];
   text_beat_type    expected_text [$];
   int               mismatches = 0;

   // sender pacing
   int burst_left;
   int gap_left;

   // receiver pacing
   rx_mode_type  rx_mode;
   int           rx_mode_left;
   logic [7:0]   rx_mask;
   int           hold_left;
   logic         long_hold_done;
   int           beats_seen;

   always #5 clock = ~clock;

   // Expected characters for one number, appended to expected_text
   function automatic void spell_decimal(input number_item_type item);
      logic [VW-1:0]                     magnitude;
      logic [s2d_pkg::DIGIT_WIDTH-1:0]   digits [s2d_pkg::MAX_DIGITS_DEF];
      int                                count;
      text_beat_type                     beat;
      magnitude = item.value[VW-1] ? (~item.value + 1'b1) : item.value;
      count = 0;
      do begin
         digits[count] = s2d_pkg::DIGIT_WIDTH'(magnitude % 10);
         magnitude     = magnitude / 10;
         count++;
      end while (magnitude != 0 && count < s2d_pkg::MAX_DIGITS_DEF);
      beat.destination = item.destination;
      if (item.value[VW-1]) begin
         beat.character = s2d_pkg::ASCII_MINUS;
         beat.last      = 1'b0;
         expected_text.push_back(beat);
      end
      for (int i = count - 1; i >= 0; i--) begin
         beat.character = s2d_pkg::ASCII_ZERO + digits[i];
         beat.last      = (i == 0);
         expected_text.push_back(beat);
      end
   endfunction

   // Random number, mixing full-range values with short ones and decade edges
   function automatic logic signed [VW-1:0] random_value();
      logic signed [VW-1:0] v;
      logic signed [VW-1:0] decade;
      int                   k;
      case ($urandom_range(0, 5))
         0, 5: v = $urandom;
         1: v = $urandom_range(0, 20);
         2: v = $urandom >> $urandom_range(0, VW - 1);
         3: begin
            decade = 1;
            k = $urandom_range(0, 9);
            for (int i = 0; i < k; i++) decade = decade * 10;
            v = decade + $urandom_range(0, 2) - 1;
         end
         default: begin
            v = $urandom_range(0, 40);
            v = $urandom_range(0, 1) ? (32'sh7FFF_FFFF - v) : (32'sh8000_0000 + v);
         end
      endcase
      if (v != 32'sh8000_0000 && $urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   // Sender: bursts of beats with random gaps between them
   always @(posedge clock) begin : sender
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left     = 0;
         gap_left       = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) spell_decimal(numbers_to_send.pop_front());
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 8);
               gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (numbers_to_send.size() > 0) begin
               burst_left--;
               req_chan.valid       <= 1'b1;
               req_chan.value       <= numbers_to_send[0].value;
               req_chan.destination <= numbers_to_send[0].destination;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each beat and stalls on its own pattern
   always @(posedge clock) begin : receiver
      text_beat_type want;
      logic          next_ready;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_mode        = RX_OPEN;
         rx_mode_left   = 0;
         rx_mask        = 8'hFF;
         hold_left      = 0;
         long_hold_done = 1'b0;
         beats_seen     = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            beats_seen++;
            if (expected_text.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display("unexpected beat: char %0d last %0b dest %0d",
                           rsp_chan.character, rsp_chan.last, rsp_chan.destination_res);
               mismatches++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_chan.character !== want.character || rsp_chan.last !== want.last ||
                   rsp_chan.destination_res !== want.destination) begin
                  if (mismatches < MAX_REPORTS)
                     $display("mismatch: expected char %0d last %0b dest %0d,",
                              want.character, want.last, want.destination,
                              " got char %0d last %0b dest %0d",
                              rsp_chan.character, rsp_chan.last, rsp_chan.destination_res);
                  mismatches++;
               end
            end
         end
         // one long hold-off so the block backs up into its input
         if (!long_hold_done && beats_seen >= 150) begin
            long_hold_done = 1'b1;
            hold_left      = 400;
         end
         if (rx_mode_left == 0) begin
            rx_mode_left = $urandom_range(50, 250);
            rx_mode      = rx_mode_type'($urandom_range(0, 2));
            rx_mask      = 8'($urandom_range(1, 255));
         end
         rx_mode_left--;
         case (rx_mode)
            RX_RANDOM: next_ready = ($urandom_range(0, 9) < 7);
            RX_MASK: begin
               next_ready = rx_mask[0];
               rx_mask    = {rx_mask[0], rx_mask[7:1]};
            end
            default:   next_ready = 1'b1;
         endcase
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end
         rsp_chan.ready <= next_ready;
      end
   end

   initial begin : stimulus
      logic signed [VW-1:0] corners [18] = '{
         0, 1, -1, 9, 10, -9, -10, 99, 100, -100, 123456789, -987654321,
         999999999, 1000000000, -1000000000,
         32'sh7FFF_FFFF, 32'sh8000_0001, 32'sh8000_0000
      };
      logic [s2d_pkg::DEST_WIDTH-1:0] dest_cycle [4] = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
      number_item_type item;

      reset = 1'b1;

      foreach (corners[i]) begin
         item.value       = corners[i];
         item.destination = dest_cycle[i % 4];
         numbers_to_send.push_back(item);
      end
      for (int i = 0; i < RANDOM_NUMS; i++) begin
         item.value       = random_value();
         item.destination = s2d_pkg::DEST_WIDTH'($urandom_range(0, 255));
         numbers_to_send.push_back(item);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (numbers_to_send.size() != 0 || req_chan.valid);
      do @(posedge clock); while (expected_text.size() != 0);
      repeat (60) @(posedge clock);

      if (mismatches == 0 && expected_text.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
